// File: design/bfmc_pkg.sv
// Package: shared constants and types for the mip chain block.
`default_nettype none
package bfmc_pkg;
    localparam int MaxSide     = 4096;
    localparam int MaxLevels   = 16;
    localparam int SideW       = 13;
    localparam int PosW        = 12;
    localparam int AddrW       = 12;
    localparam int SumW        = 36;
    localparam int LvlW        = 4;
    localparam int QDepth      = 4;
    localparam int QPtrW       = 2;
    localparam logic [SideW-1:0] SideReset = 13'd256;
    localparam logic [1:0] RegImageSide = 2'd0;

    // one base pixel handed from the front to the back
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pix_t;

    // one result transaction
    typedef struct packed {
        logic [LvlW-1:0] mip_level;
        logic [10:0]     pos_x;
        logic [10:0]     pos_y;
        logic [7:0]      out_red;
        logic [7:0]      out_green;
        logic [7:0]      out_blue;
        logic [7:0]      out_alpha;
        logic            burst_last;
    } res_t;
endpackage
`default_nettype wire

// File: design/bfmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bfmc_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(Depth)-1:0]  waddr,
    input  wire [Width-1:0]          wdata,
    input  wire [$clog2(Depth)-1:0]  raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: design/bfmc_front.sv
// Front end: accepts base pixels into a short queue.
`default_nettype none
module bfmc_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 flush,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire bfmc_pkg::pix_t in_pix,
    output logic                q_valid,
    input  wire                 q_pop,
    output bfmc_pkg::pix_t      q_pix
);
    import bfmc_pkg::*;
    pix_t                 q_reg [QDepth];
    logic [QPtrW-1:0]     wp_reg, rp_reg;
    logic [QPtrW:0]       cnt_reg;
    logic                 push, pop;

    assign in_ready = (cnt_reg != (QPtrW+1)'(QDepth));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_pix    = q_reg[rp_reg];

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= in_pix;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn || flush) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop)  rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

// File: design/bfmc_back.sv
// Back end: walks one pixel down the levels, one level at a time, and takes the next pixel only when idle.
`default_nettype none
module bfmc_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 restart,
    input  wire [bfmc_pkg::SideW-1:0] side_in,
    input  wire                 q_valid,
    output logic                q_pop,
    input  wire bfmc_pkg::pix_t q_pix,
    output logic                m_valid,
    input  wire                 m_ready,
    output bfmc_pkg::res_t      m_res
);
    import bfmc_pkg::*;

    localparam logic [1:0] StIdle = 2'd0, StWalk = 2'd1, StRead = 2'd2, StOut = 2'd3;

    logic [1:0]        st_reg;
    logic [SideW-1:0]  side;
    logic [LvlW:0]     levels;
    logic [LvlW-1:0]   lvl_reg;   // stream index k = level-1
    logic [SumW-1:0]   pix_reg;   // current pixel, 9-bit lanes
    logic [AddrW-1:0]  off_reg;
    logic [SumW-1:0]   hsum_reg;
    logic [PosW-1:0]   x_hold_reg, y_hold_reg;
    logic [PosW-1:0]   col_reg [MaxLevels];
    logic [PosW-1:0]   row_reg [MaxLevels];
    logic [SumW-1:0]   part_reg [MaxLevels];
    res_t              ob_reg;
    logic              ob_v_reg;
    logic              pend_reg;  // result staged but not final
    res_t              pend_res_reg;

    logic [SideW-1:0]  w;
    logic [PosW-1:0]   lw, x, y;
    logic [SideW-1:0]  lw2;       // twice the level side, odd tail excluded
    logic              last_lvl;
    logic [SumW-1:0]   hsum, rd;
    logic              ram_we;
    logic [AddrW-1:0]  ram_addr, rd_addr;
    logic [7:0]        avg [4];
    logic              room, ob_load;

    // effective side and level count
    always_comb begin
        side = (side_in > SideW'(MaxSide)) ? SideW'(MaxSide) : side_in;
        levels = (LvlW+1)'(1);
        for (int i = 1; i < MaxLevels; i++) begin
            if ((side >> i) > SideW'(1)) levels = (LvlW+1)'(i + 1);
        end
    end

    assign w        = side >> lvl_reg;
    assign lw       = PosW'(w >> 1);
    assign lw2      = {lw, 1'b0};
    assign x        = col_reg[lvl_reg];
    assign y        = row_reg[lvl_reg];
    assign last_lvl = ((LvlW+1)'(lvl_reg) + 1'b1 + 1'b1 >= levels) ||
                      ((LvlW+1)'(lvl_reg) + 1'b1 == (LvlW+1)'(MaxLevels));
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            hsum[9*c +: 9] = part_reg[lvl_reg][9*c +: 9] + pix_reg[9*c +: 9];
        end
    end
    assign ram_addr = off_reg + AddrW'(x >> 1);
    // hold the read address while a result waits for room
    assign rd_addr  = (st_reg == StRead) ? off_reg + AddrW'(x_hold_reg >> 1) : ram_addr;
    assign ram_we   = (st_reg == StWalk) && x[0] && !y[0] &&
                      SideW'(x) < lw2 && SideW'(y) < lw2;

    bfmc_ram #(.Width(SumW), .Depth(MaxSide)) u_rows (
        .aclk(aclk), .we(ram_we), .waddr(ram_addr), .wdata(hsum),
        .raddr(rd_addr), .rdata(rd)
    );

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            avg[c] = 8'((11'(hsum_reg[9*c +: 9]) + 11'(rd[9*c +: 9])) >> 2);
        end
    end

    assign q_pop   = (st_reg == StIdle) && q_valid;
    assign m_valid = ob_v_reg;
    assign m_res   = ob_reg;

    // output register load
    assign room    = !ob_v_reg || m_ready;
    assign ob_load = room && pend_reg && (st_reg == StRead || st_reg == StOut);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            st_reg   <= StIdle;
            ob_v_reg <= 1'b0;
            pend_reg <= 1'b0;
            for (int i = 0; i < MaxLevels; i++) begin
                col_reg[i]  <= '0;
                row_reg[i]  <= '0;
                part_reg[i] <= '0;
            end
        end else begin
            if (ob_load) begin
                ob_v_reg <= 1'b1;
            end else if (m_ready) begin
                ob_v_reg <= 1'b0;
            end
            case (st_reg)
                StIdle: begin
                    // pixels are consumed and dropped when no level exists
                    if (q_pop && levels >= (LvlW+1)'(2)) begin
                        pix_reg[8:0]   <= {1'b0, q_pix.red};
                        pix_reg[17:9]  <= {1'b0, q_pix.green};
                        pix_reg[26:18] <= {1'b0, q_pix.blue};
                        pix_reg[35:27] <= {1'b0, q_pix.alpha};
                        lvl_reg <= '0;
                        off_reg <= '0;
                        st_reg  <= StWalk;
                    end
                end
                StWalk: begin
                    // advance raster position of this stream
                    if (SideW'(x) + 1'b1 >= w) begin
                        col_reg[lvl_reg] <= '0;
                        row_reg[lvl_reg] <= (SideW'(y) + 1'b1 >= w) ? '0 : y + 1'b1;
                    end else begin
                        col_reg[lvl_reg] <= x + 1'b1;
                    end
                    x_hold_reg <= x;
                    y_hold_reg <= y;
                    hsum_reg   <= hsum;
                    if (SideW'(x) >= lw2 || SideW'(y) >= lw2) begin
                        st_reg <= StOut;
                    end else if (!x[0]) begin
                        part_reg[lvl_reg] <= pix_reg;
                        st_reg <= StOut;
                    end else if (!y[0]) begin
                        st_reg <= StOut;
                    end else begin
                        st_reg <= StRead;
                    end
                end
                StRead: begin
                    // one result produced; wait for room, then move on
                    if (room) begin
                        if (pend_reg) begin
                            ob_reg <= pend_res_reg;
                        end
                        pend_reg <= 1'b1;
                        pend_res_reg <= '{mip_level: lvl_reg + 1'b1,
                                          pos_x: x_hold_reg[11:1],
                                          pos_y: y_hold_reg[11:1],
                                          out_red: avg[0], out_green: avg[1],
                                          out_blue: avg[2], out_alpha: avg[3],
                                          burst_last: 1'b0};
                        for (int c = 0; c < 4; c++) pix_reg[9*c +: 9] <= {1'b0, avg[c]};
                        off_reg <= off_reg + AddrW'(lw);
                        if (last_lvl) begin
                            st_reg <= StOut;
                        end else begin
                            lvl_reg <= lvl_reg + 1'b1;
                            st_reg  <= StWalk;
                        end
                    end
                end
                default: begin
                    // end of burst: flush the staged result marked last
                    if (!pend_reg) begin
                        st_reg <= StIdle;
                    end else if (room) begin
                        ob_reg   <= {pend_res_reg[$bits(res_t)-1:1], 1'b1};
                        pend_reg <= 1'b0;
                        st_reg   <= StIdle;
                    end
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: design/box_filter_mip_chain_top.sv
// Top level: mip chain block with stream ports and register port.
// Accepts one RGBA8 base pixel per transaction and emits all mip pixels it
// completes, lowest level first, burst_last on the last. The back end takes
// each pixel from the queue, then visits the levels in turn, with a row-pair
// RAM read for each level that completes, until one does not complete or the
// last is reached, and closes in a final state that sends the last result;
// output stalls hold the back end in place. It takes the next pixel only once
// back in idle, and the four-entry queue in front absorbs short bursts.
// Writing image_side restarts the image.
`default_nettype none
module box_filter_mip_chain_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [0:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // red, green, blue, alpha
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,   // mip_level, pos_x, pos_y, out_red..out_alpha
    output logic        m_tlast    // burst_last
);
    import bfmc_pkg::*;
    logic [SideW-1:0] side_reg;
    logic             wr;
    pix_t             in_pix, q_pix;
    logic             q_valid, q_pop;
    res_t             res;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && (paddr == 1'b0);
    assign prdata = {19'd0, side_reg};

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= SideReset;
        end else if (wr) begin
            side_reg <= pwdata[SideW-1:0];
        end
    end

    assign in_pix = '{red: s_tdata[7:0], green: s_tdata[15:8],
                      blue: s_tdata[23:16], alpha: s_tdata[31:24]};

    bfmc_front u_front (
        .aclk(aclk), .aresetn(aresetn), .flush(wr),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_pix(in_pix),
        .q_valid(q_valid), .q_pop(q_pop), .q_pix(q_pix)
    );

    bfmc_back u_back (
        .aclk(aclk), .aresetn(aresetn), .restart(wr), .side_in(side_reg),
        .q_valid(q_valid), .q_pop(q_pop), .q_pix(q_pix),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_res(res)
    );

    assign m_tdata = {6'd0, res.out_alpha, res.out_blue, res.out_green,
                      res.out_red, res.pos_y, res.pos_x, res.mip_level};
    assign m_tlast = res.burst_last;
endmodule
`default_nettype wire

// File: design/bfmc_checker.sv
// Port checker for the mip chain block, bound to the top level.
`default_nettype none
module bfmc_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [63:0] m_tdata,
    input wire        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result dropped while stalled");
    a_lvl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3:0] != 4'd0)
        else $error("level zero emitted");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[63:58] == 6'd0)
        else $error("padding not zero");
endmodule
bind box_filter_mip_chain_top bfmc_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
